// ----- sv/perf_pkg.sv -----
// shared constants and types for the pointer event report queue
package perf_pkg;

	localparam int RING_DEPTH_DEF = 256;

	// event types
	localparam logic [4:0] EV_SYN = 5'd0;
	localparam logic [4:0] EV_KEY = 5'd1;
	localparam logic [4:0] EV_REL = 5'd2;
	localparam logic [4:0] EV_ABS = 5'd3;

	// result status codes
	localparam logic [2:0] ST_ABSORBED = 3'd0;
	localparam logic [2:0] ST_QUEUED   = 3'd1;
	localparam logic [2:0] ST_DROPPED  = 3'd2;
	localparam logic [2:0] ST_POP_DATA = 3'd3;
	localparam logic [2:0] ST_POP_EMPTY = 3'd4;

	// device classes
	localparam logic [1:0] DEV_MOUSE    = 2'd0;
	localparam logic [1:0] DEV_TOUCHPAD = 2'd1;
	localparam logic [1:0] DEV_TABLET   = 2'd2;
	localparam logic [1:0] DEV_JOYSTICK = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_CLASS  = 3'd0;
	localparam logic [2:0] REG_SCR_W  = 3'd1;
	localparam logic [2:0] REG_SCR_H  = 3'd2;
	localparam logic [2:0] REG_SPAN_X = 3'd3;
	localparam logic [2:0] REG_SPAN_Y = 3'd4;

	localparam logic [12:0] SCR_W_RESET = 13'd1024;
	localparam logic [12:0] SCR_H_RESET = 13'd768;

	// divider handshake
	typedef struct packed {
		logic        start;
		logic        neg;
		logic [63:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic        busy;
		logic [63:0] quotient;
	} div_rsp_t;

	// button index for a key code, bit 3 set when the code is not a button
	function automatic logic [3:0] button_index(input logic [9:0] code);
		logic [3:0] r;
		r = 4'd8;
		case (code)
			10'h14a, 10'h100, 10'h115, 10'h110: r = 4'd0;
			10'h104, 10'h114:                   r = 4'd4;
			10'h14b, 10'h101, 10'h111:          r = 4'd1;
			10'h103, 10'h116, 10'h113:          r = 4'd3;
			10'h102, 10'h14c, 10'h112:          r = 4'd2;
			default:                            r = 4'd8;
		endcase
		return r;
	endfunction

endpackage

// ----- sv/perf_ram.sv -----
// generic single write port ram with registered read
module perf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/perf_div.sv -----
// shared restoring divider, one quotient bit per cycle, signed truncating result
module perf_div (
	input  logic                clk,
	input  logic                arst_n,
	input  perf_pkg::div_req_t  req,
	output perf_pkg::div_rsp_t  rsp
);

	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [15:0] den_q;
	logic        neg_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [64:0] trial;
	logic [63:0] rem_sh;

	// shift in the next dividend bit and try to subtract
	always_comb begin
		rem_sh = {rem_q[62:0], quo_q[63]};
		trial  = {1'b0, rem_sh} - {49'd0, den_q};
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
			neg_q <= req.neg;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.busy     = busy_q;
	assign rsp.quotient = neg_q ? (~quo_q + 64'd1) : quo_q;

`ifndef SYNTHESIS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without busy");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q != 7'd64 |-> cnt_q != 7'd0)
		else $error("divider count underflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q <= 7'd64)
		else $error("divider count out of range");
`endif

endmodule

// ----- sv/pointer_event_report_fifo_top.sv -----
// top level of the pointer event report queue
// events, keys and syncs finish in decode; a pop then reads the ram (registered read);
// a mouse or tablet absolute event runs the 64-step shared divider plus two multiply
// steps; touchpad moves add an update state. busy stays high until the result cycle.
// a new item is taken only when the last is done; results are one-cycle strobes, no stall.
// reset: asynchronous, clears accumulators, pointers and registers; ram needs no clear.
module pointer_event_report_fifo_top #(
	parameter int RING_DEPTH = perf_pkg::RING_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               req_type,
	input  logic [4:0]         ev_type,
	input  logic [9:0]         ev_code,
	input  logic signed [31:0] ev_value,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output logic               done,
	output logic [2:0]         status,
	output logic               notify,
	output logic signed [31:0] out_dx,
	output logic signed [31:0] out_dy,
	output logic signed [31:0] out_dz,
	output logic [4:0]         out_buttons
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam logic [AW-1:0] PTR_LAST = AW'(RING_DEPTH - 1);

	// sequencer codes
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_POPRD  = 4'd2;
	localparam logic [3:0] S_POPOUT = 4'd3;
	localparam logic [3:0] S_MUL1   = 4'd4;
	localparam logic [3:0] S_DIVGO  = 4'd5;
	localparam logic [3:0] S_DIVW   = 4'd6;
	localparam logic [3:0] S_MUL2   = 4'd7;
	localparam logic [3:0] S_POS    = 4'd8;
	localparam logic [3:0] S_TPAD   = 4'd9;

	logic [3:0] state_q;

	// configuration
	logic [1:0]  dev_class_q;
	logic [12:0] scr_w_q, scr_h_q;
	logic [15:0] span_x_q, span_y_q;

	// accumulator state
	logic [31:0] acc_dx_q, acc_dy_q, acc_dz_q, last_x_q, last_y_q;
	logic [4:0]  buttons_q;
	logic [1:0]  touch_q;
	logic [AW-1:0] wptr_q, rptr_q;

	// latched item
	logic        req_q;
	logic [4:0]  type_q;
	logic [9:0]  code_q;
	logic [31:0] val_q;

	// arithmetic work registers
	logic signed [63:0] num_q;
	logic [15:0]        size_q;
	logic signed [63:0] prod_q;
	logic               axis_y_q;

	// result registers
	logic        done_q;
	logic [2:0]  status_q;
	logic        notify_q;
	logic [31:0] odx_q, ody_q, odz_q;
	logic [4:0]  obt_q;

	// ring
	logic          ring_we;
	logic [AW-1:0] ring_raddr;
	logic [100:0]  ring_wdata, ring_rdata;

	perf_pkg::div_req_t div_req;
	perf_pkg::div_rsp_t div_rsp;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + AW'(1);
	endfunction

	assign ring_raddr = ring_next(rptr_q);
	assign ring_wdata = {acc_dx_q, acc_dy_q, acc_dz_q, buttons_q};

	perf_ram #(.WIDTH(101), .DEPTH(RING_DEPTH)) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (wptr_q),
		.wdata (ring_wdata),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	perf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// touchpad raised count and difference
	logic [1:0]         touch_adv;
	logic signed [32:0] tp_diff;
	logic signed [32:0] tp_quot;
	logic [31:0]        tp_last;
	always_comb begin
		touch_adv = (touch_q != 2'd0 && touch_q != 2'd3) ? touch_q + 2'd1 : touch_q;
		tp_last   = code_q[0] ? last_y_q : last_x_q;
		tp_diff   = {val_q[31], val_q} - {tp_last[31], tp_last};
		// truncate toward zero by biasing negative values
		tp_quot   = (tp_diff + (tp_diff[32] ? 33'sd7 : 33'sd0)) >>> 3;
	end

	// divider request from the work registers
	always_comb begin
		div_req.start    = (state_q == S_DIVGO);
		div_req.neg      = num_q[63];
		div_req.dividend = num_q[63] ? 64'(-num_q) : 64'(num_q);
		div_req.divisor  = size_q;
	end

	logic [3:0] bidx;
	assign bidx    = perf_pkg::button_index(code_q);
	assign ring_we = (state_q == S_DECODE) && !req_q && type_q == perf_pkg::EV_SYN
		&& code_q == 10'd0 && rptr_q != wptr_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_class_q <= perf_pkg::DEV_MOUSE;
			scr_w_q     <= perf_pkg::SCR_W_RESET;
			scr_h_q     <= perf_pkg::SCR_H_RESET;
			span_x_q    <= '0;
			span_y_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				perf_pkg::REG_CLASS:  dev_class_q <= cfg_data[1:0];
				perf_pkg::REG_SCR_W:  scr_w_q     <= cfg_data[12:0];
				perf_pkg::REG_SCR_H:  scr_h_q     <= cfg_data[12:0];
				perf_pkg::REG_SPAN_X: span_x_q    <= cfg_data;
				perf_pkg::REG_SPAN_Y: span_y_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// item latch and arithmetic work registers
	always_ff @(posedge clk) begin
		if (start && state_q == S_IDLE) begin
			req_q  <= req_type;
			type_q <= ev_type;
			code_q <= ev_code;
			val_q  <= ev_value;
		end
		case (state_q)
			S_DECODE: begin
				axis_y_q <= code_q[0];
				// value times screen size, one 32x13 multiply
				prod_q <= code_q[0]
					? $signed(val_q) * $signed({1'b0, scr_h_q})
					: $signed(val_q) * $signed({1'b0, scr_w_q});
				if (code_q[0]) begin
					size_q <= (span_y_q != 16'd0) ? span_y_q
						: (scr_h_q != 13'd0) ? {3'd0, scr_h_q} : 16'd1;
				end else begin
					size_q <= (span_x_q != 16'd0) ? span_x_q
						: (scr_w_q != 13'd0) ? {3'd0, scr_w_q} : 16'd1;
				end
			end
			S_MUL1: begin
				num_q <= prod_q - 64'(signed'(axis_y_q ? last_y_q : last_x_q));
			end
			S_MUL2: begin
				// accumulated delta times span
				prod_q <= $signed(axis_y_q ? acc_dy_q : acc_dx_q) * $signed({1'b0, size_q});
			end
			default: ;
		endcase
	end

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			acc_dx_q  <= '0;
			acc_dy_q  <= '0;
			acc_dz_q  <= '0;
			last_x_q  <= '0;
			last_y_q  <= '0;
			buttons_q <= '0;
			touch_q   <= '0;
			wptr_q    <= AW'(1);
			rptr_q    <= '0;
			done_q    <= 1'b0;
			status_q  <= perf_pkg::ST_ABSORBED;
			notify_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					status_q <= perf_pkg::ST_ABSORBED;
					notify_q <= 1'b0;
					state_q  <= S_IDLE;
					done_q   <= 1'b1;
					if (req_q) begin
						done_q <= 1'b0;
						if (ring_next(rptr_q) == wptr_q) begin
							status_q <= perf_pkg::ST_POP_EMPTY;
							done_q   <= 1'b1;
						end else begin
							state_q <= S_POPRD;
						end
					end else if (type_q == perf_pkg::EV_ABS) begin
						if (dev_class_q == perf_pkg::DEV_TOUCHPAD) begin
							touch_q <= touch_adv;
							done_q  <= 1'b0;
							state_q <= S_TPAD;
						end else if (dev_class_q != perf_pkg::DEV_JOYSTICK
							&& (code_q == 10'd0 || code_q == 10'd1)) begin
							done_q  <= 1'b0;
							state_q <= S_MUL1;
						end
					end else if (type_q == perf_pkg::EV_REL) begin
						if (code_q == 10'd0) begin
							acc_dx_q <= acc_dx_q + val_q;
						end else if (code_q == 10'd1) begin
							acc_dy_q <= acc_dy_q - val_q;
						end else if (code_q == 10'd8) begin
							acc_dz_q <= acc_dz_q - val_q;
						end
					end else if (type_q == perf_pkg::EV_KEY) begin
						if (code_q == 10'h14a && dev_class_q == perf_pkg::DEV_TOUCHPAD) begin
							touch_q <= $signed(val_q) < 0 ? 2'd0
								: ($signed(val_q) > 3 ? 2'd3 : val_q[1:0]);
						end else if (!bidx[3]) begin
							if (val_q == 32'd0) begin
								buttons_q[bidx[2:0]] <= 1'b0;
							end else if (val_q == 32'd1) begin
								buttons_q[bidx[2:0]] <= 1'b1;
							end
						end
					end else if (type_q == perf_pkg::EV_SYN && code_q == 10'd0) begin
						notify_q <= 1'b1;
						if (rptr_q != wptr_q) begin
							wptr_q   <= ring_next(wptr_q);
							acc_dx_q <= '0;
							acc_dy_q <= '0;
							acc_dz_q <= '0;
							status_q <= perf_pkg::ST_QUEUED;
						end else begin
							status_q <= perf_pkg::ST_DROPPED;
						end
					end
				end
				S_POPRD: begin
					state_q <= S_POPOUT;
				end
				S_POPOUT: begin
					rptr_q   <= ring_next(rptr_q);
					status_q <= perf_pkg::ST_POP_DATA;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_TPAD: begin
					if (code_q == 10'd0) begin
						if (touch_q == 2'd3) begin
							acc_dx_q <= acc_dx_q + tp_quot[31:0];
						end
						last_x_q <= val_q;
					end else if (code_q == 10'd1) begin
						if (touch_q == 2'd3) begin
							acc_dy_q <= acc_dy_q - tp_quot[31:0];
						end
						last_y_q <= val_q;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_MUL1: begin
					state_q <= S_DIVGO;
				end
				S_DIVGO: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (div_rsp.done) begin
						if (axis_y_q) begin
							acc_dy_q <= acc_dy_q - div_rsp.quotient[31:0];
						end else begin
							acc_dx_q <= acc_dx_q + div_rsp.quotient[31:0];
						end
						state_q <= S_MUL2;
					end
				end
				S_MUL2: begin
					state_q <= S_POS;
				end
				S_POS: begin
					if (axis_y_q) begin
						last_y_q <= last_y_q - prod_q[31:0];
					end else begin
						last_x_q <= last_x_q + prod_q[31:0];
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// popped payload, zero unless pop data
	always_ff @(posedge clk) begin
		if (state_q == S_POPOUT) begin
			{odx_q, ody_q, odz_q, obt_q} <= ring_rdata;
		end else if (state_q != S_IDLE) begin
			{odx_q, ody_q, odz_q, obt_q} <= '0;
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign notify      = notify_q;
	assign out_dx      = odx_q;
	assign out_dy      = ody_q;
	assign out_dz      = odz_q;
	assign out_buttons = obt_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not start work");
	a_ring_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wptr_q <= PTR_LAST && rptr_q <= PTR_LAST)
		else $error("ring pointer out of range");
	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == perf_pkg::ST_POP_DATA |-> $past(state_q) == S_POPOUT)
		else $error("pop data without ram read");
`endif

endmodule

// ----- test/pointer_event_report_fifo_top_tb.sv -----
// self-checking testbench for the pointer event report queue
module pointer_event_report_fifo_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic        req;
		logic [4:0]  typ;
		logic [9:0]  code;
		logic [31:0] val;
	} event_item_t;

	typedef struct {
		logic [2:0]  status;
		logic        notify;
		logic [31:0] dx;
		logic [31:0] dy;
		logic [31:0] dz;
		logic [4:0]  buttons;
	} report_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic req_type = 1'b0;
	logic [4:0] ev_type = '0;
	logic [9:0] ev_code = '0;
	logic signed [31:0] ev_value = '0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic busy, done, notify;
	logic [2:0] status;
	logic signed [31:0] out_dx, out_dy, out_dz;
	logic [4:0] out_buttons;

	pointer_event_report_fifo_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .ev_type(ev_type), .ev_code(ev_code), .ev_value(ev_value),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .status(status), .notify(notify),
		.out_dx(out_dx), .out_dy(out_dy), .out_dz(out_dz), .out_buttons(out_buttons)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	event_item_t    pending_items[$];
	report_result_t expected_results[$];
	event_item_t    cur_item;
	int sender_idle_pct = 0;
	int errors = 0;
	int n_queued = 0, n_dropped = 0, n_popped = 0, n_empty = 0;

	// predictor state
	logic [1:0]  m_class;
	logic [12:0] m_scr_w, m_scr_h;
	logic [15:0] m_span_x, m_span_y;
	logic [31:0] m_acc_dx, m_acc_dy, m_acc_dz, m_last_x, m_last_y;
	logic [4:0]  m_buttons;
	logic [1:0]  m_touch;
	logic [31:0] r_dx[256], r_dy[256], r_dz[256];
	logic [4:0]  r_bt[256];
	logic [7:0]  m_wr, m_rd;

	function automatic longint sx(logic [31:0] v);
		return longint'(signed'(v));
	endfunction

	// absolute axis handling per device class
	function automatic void apply_abs(logic [9:0] code, longint v);
		longint size;
		if (m_class == perf_pkg::DEV_JOYSTICK) return;
		if (m_class == perf_pkg::DEV_TOUCHPAD) begin
			if (m_touch != 0 && m_touch < 3) m_touch = m_touch + 1;
			if (code == 0) begin
				if (m_touch == 3) m_acc_dx = 32'(sx(m_acc_dx) + (v - sx(m_last_x)) / 8);
				m_last_x = 32'(v);
			end else if (code == 1) begin
				if (m_touch == 3) m_acc_dy = 32'(sx(m_acc_dy) - (v - sx(m_last_y)) / 8);
				m_last_y = 32'(v);
			end
			return;
		end
		if (code == 0) begin
			size = (m_span_x != 0) ? longint'(m_span_x) : longint'(m_scr_w);
			if (size == 0) size = 1;
			m_acc_dx = 32'(sx(m_acc_dx) + (v * longint'(m_scr_w) - sx(m_last_x)) / size);
			m_last_x = 32'(sx(m_last_x) + sx(m_acc_dx) * size);
		end else if (code == 1) begin
			size = (m_span_y != 0) ? longint'(m_span_y) : longint'(m_scr_h);
			if (size == 0) size = 1;
			m_acc_dy = 32'(sx(m_acc_dy) - (v * longint'(m_scr_h) - sx(m_last_y)) / size);
			m_last_y = 32'(sx(m_last_y) - sx(m_acc_dy) * size);
		end
	endfunction

	// button and touch keys
	function automatic void apply_key(logic [9:0] code, longint v);
		int idx;
		if (code == 10'h14a && m_class == perf_pkg::DEV_TOUCHPAD) begin
			m_touch = (v < 0) ? 2'd0 : ((v > 3) ? 2'd3 : 2'(v));
			return;
		end
		case (code)
			10'h14a, 10'h100, 10'h115, 10'h110: idx = 0;
			10'h104, 10'h114:                   idx = 4;
			10'h14b, 10'h101, 10'h111:          idx = 1;
			10'h103, 10'h116, 10'h113:          idx = 3;
			10'h102, 10'h14c, 10'h112:          idx = 2;
			default: return;
		endcase
		if (v == 0) m_buttons[idx] = 1'b0;
		else if (v == 1) m_buttons[idx] = 1'b1;
	endfunction

	function automatic report_result_t predict_report(event_item_t it);
		report_result_t r;
		longint v;
		v = sx(it.val);
		r = '{perf_pkg::ST_ABSORBED, 1'b0, 32'd0, 32'd0, 32'd0, 5'd0};
		if (it.req) begin
			if (8'(m_rd + 1) == m_wr) r.status = perf_pkg::ST_POP_EMPTY;
			else begin
				m_rd = m_rd + 1;
				r.dx = r_dx[m_rd];
				r.dy = r_dy[m_rd];
				r.dz = r_dz[m_rd];
				r.buttons = r_bt[m_rd];
				r.status = perf_pkg::ST_POP_DATA;
			end
		end else if (it.typ == perf_pkg::EV_ABS) apply_abs(it.code, v);
		else if (it.typ == perf_pkg::EV_REL) begin
			if (it.code == 0) m_acc_dx = 32'(sx(m_acc_dx) + v);
			else if (it.code == 1) m_acc_dy = 32'(sx(m_acc_dy) - v);
			else if (it.code == 8) m_acc_dz = 32'(sx(m_acc_dz) - v);
		end else if (it.typ == perf_pkg::EV_KEY) apply_key(it.code, v);
		else if (it.typ == perf_pkg::EV_SYN && it.code == 0) begin
			r.notify = 1'b1;
			if (m_rd != m_wr) begin
				r_dx[m_wr] = m_acc_dx;
				r_dy[m_wr] = m_acc_dy;
				r_dz[m_wr] = m_acc_dz;
				r_bt[m_wr] = m_buttons;
				m_wr = m_wr + 1;
				m_acc_dx = 0;
				m_acc_dy = 0;
				m_acc_dz = 0;
				r.status = perf_pkg::ST_QUEUED;
			end else r.status = perf_pkg::ST_DROPPED;
		end
		return r;
	endfunction

	// driver: presents pending items, holds each until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) expected_results.push_back(predict_report(cur_item));
			if (!start || !busy) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
					cur_item = pending_items.pop_front();
					req_type <= cur_item.req;
					ev_type <= cur_item.typ;
					ev_code <= cur_item.code;
					ev_value <= cur_item.val;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: compares each strobed result with the oldest expectation
	always @(posedge clk) begin
		report_result_t e;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, status %0d", $time, status);
				errors++;
			end else begin
				e = expected_results.pop_front();
				case (e.status)
					perf_pkg::ST_QUEUED: n_queued++;
					perf_pkg::ST_DROPPED: n_dropped++;
					perf_pkg::ST_POP_DATA: n_popped++;
					perf_pkg::ST_POP_EMPTY: n_empty++;
					default: ;
				endcase
				if (status !== e.status) begin
					$display("%0t: status exp %0d got %0d", $time, e.status, status);
					errors++;
				end
				if (notify !== e.notify) begin
					$display("%0t: notify exp %0d got %0d", $time, e.notify, notify);
					errors++;
				end
				if (out_dx !== e.dx) begin
					$display("%0t: out_dx exp %0d got %0d", $time, $signed(e.dx), out_dx);
					errors++;
				end
				if (out_dy !== e.dy) begin
					$display("%0t: out_dy exp %0d got %0d", $time, $signed(e.dy), out_dy);
					errors++;
				end
				if (out_dz !== e.dz) begin
					$display("%0t: out_dz exp %0d got %0d", $time, $signed(e.dz), out_dz);
					errors++;
				end
				if (out_buttons !== e.buttons) begin
					$display("%0t: out_buttons exp %h got %h", $time, e.buttons, out_buttons);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			perf_pkg::REG_CLASS:  m_class = data[1:0];
			perf_pkg::REG_SCR_W:  m_scr_w = data[12:0];
			perf_pkg::REG_SCR_H:  m_scr_h = data[12:0];
			perf_pkg::REG_SPAN_X: m_span_x = data;
			perf_pkg::REG_SPAN_Y: m_span_y = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_items.size() > 0 || expected_results.size() > 0 || start || busy)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic void add(logic req, logic [4:0] t, logic [9:0] c, logic [31:0] v);
		pending_items.push_back('{req, t, c, v});
	endfunction

	function automatic logic [9:0] pick_button();
		logic [9:0] codes[16] = '{10'h14a, 10'h100, 10'h115, 10'h110, 10'h104, 10'h114,
			10'h14b, 10'h101, 10'h111, 10'h103, 10'h116, 10'h113, 10'h102, 10'h14c,
			10'h112, 10'h14a};
		return codes[$urandom_range(15)];
	endfunction

	// mostly well-formed pointer traffic with random content, some noise
	function automatic void add_random(int pop_pct);
		int k;
		logic [31:0] v;
		k = $urandom_range(99);
		case ($urandom_range(3))
			0: v = $urandom;
			1: v = 32'($signed($urandom_range(200)) - 100);
			default: v = 32'($urandom_range(70000));
		endcase
		if (k < pop_pct) add(1'b1, 5'($urandom), 10'($urandom), $urandom);
		else if (k < pop_pct + 15) add(1'b0, perf_pkg::EV_SYN, ($urandom_range(9) == 0) ?
			10'($urandom) : 10'd0, $urandom);
		else if (k < pop_pct + 35) add(1'b0, perf_pkg::EV_REL, ($urandom_range(5) == 0) ?
			10'($urandom) : 10'($urandom_range(2) * 4 * $urandom_range(2) / 2 +
			($urandom_range(1))), v);
		else if (k < pop_pct + 55) add(1'b0, perf_pkg::EV_KEY, ($urandom_range(7) == 0) ?
			10'($urandom) : pick_button(), ($urandom_range(5) == 0) ?
			($urandom_range(1) ? $urandom : 32'($signed($urandom_range(6)) - 1)) :
			32'($urandom_range(2)));
		else if (k < 96) add(1'b0, perf_pkg::EV_ABS, ($urandom_range(7) == 0) ?
			10'($urandom) : 10'($urandom_range(1)), v);
		else add(1'b0, 5'($urandom), 10'($urandom), $urandom);
	endfunction

	// run
	initial begin
		logic [15:0] cls[8];
		int batch;
		cls = '{0, 1, 2, 3, 2, 1, 2, 0};
		m_class = perf_pkg::DEV_MOUSE;
		m_scr_w = perf_pkg::SCR_W_RESET;
		m_scr_h = perf_pkg::SCR_H_RESET;
		m_span_x = 0; m_span_y = 0;
		m_acc_dx = 0; m_acc_dy = 0; m_acc_dz = 0; m_last_x = 0; m_last_y = 0;
		m_buttons = 0; m_touch = 0; m_wr = 8'd1; m_rd = 8'd0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: empty pop, extremes, button presses and releases, unknown types and syncs
		add(1'b1, perf_pkg::EV_SYN, 10'd0, 32'd0);
		add(1'b0, perf_pkg::EV_REL, 10'd0, 32'h7fffffff);
		add(1'b0, perf_pkg::EV_REL, 10'd0, 32'h7fffffff);
		add(1'b0, perf_pkg::EV_REL, 10'd1, 32'h80000000);
		add(1'b0, perf_pkg::EV_REL, 10'd8, 32'hffffffff);
		add(1'b0, perf_pkg::EV_KEY, 10'h110, 32'd1);
		add(1'b0, perf_pkg::EV_KEY, 10'h111, 32'd1);
		add(1'b0, perf_pkg::EV_KEY, 10'h112, 32'd2);
		add(1'b0, perf_pkg::EV_KEY, 10'h113, 32'd1);
		add(1'b0, perf_pkg::EV_KEY, 10'h114, 32'd1);
		add(1'b0, perf_pkg::EV_KEY, 10'h14a, 32'd1);
		add(1'b0, perf_pkg::EV_ABS, 10'd0, 32'h7fffffff);
		add(1'b0, 5'd31, 10'h3ff, 32'hffffffff);
		add(1'b0, perf_pkg::EV_SYN, 10'd5, 32'd0);
		add(1'b0, perf_pkg::EV_SYN, 10'd0, 32'd0);
		add(1'b0, perf_pkg::EV_KEY, 10'h111, 32'd0);
		add(1'b0, perf_pkg::EV_KEY, 10'h113, 32'h80000000);
		add(1'b0, perf_pkg::EV_SYN, 10'd0, 32'd0);
		add(1'b1, 5'd0, 10'd0, 32'd0);
		add(1'b1, 5'd0, 10'd0, 32'd0);
		add(1'b1, 5'd0, 10'd0, 32'd0);
		wait_idle();

		// random phases over several register settings
		for (batch = 0; batch < 8; batch++) begin
			sender_idle_pct = (batch < 3) ? 19 : ((batch < 6) ? 70 : 0);
			write_reg(perf_pkg::REG_CLASS, cls[batch]);
			case (batch)
				0: begin
					write_reg(perf_pkg::REG_SCR_W, 16'd1);
					write_reg(perf_pkg::REG_SCR_H, 16'd4096);
				end
				1: begin
					write_reg(perf_pkg::REG_SCR_W, 16'd4096);
					write_reg(perf_pkg::REG_SCR_H, 16'd1);
				end
				2: begin
					write_reg(perf_pkg::REG_SPAN_X, 16'd0);
					write_reg(perf_pkg::REG_SPAN_Y, 16'd65535);
				end
				4: begin
					write_reg(perf_pkg::REG_SCR_W, 16'd0); write_reg(perf_pkg::REG_SCR_H, 16'd0);
					write_reg(perf_pkg::REG_SPAN_X, 16'd0); write_reg(perf_pkg::REG_SPAN_Y, 16'd0);
				end
				6: begin
					write_reg(perf_pkg::REG_SCR_W, 16'($urandom_range(4096, 1)));
					write_reg(perf_pkg::REG_SCR_H, 16'hffff);
					write_reg(perf_pkg::REG_SPAN_X, 16'hffff);
					write_reg(perf_pkg::REG_SPAN_Y, 16'($urandom_range(65535)));
				end
				default: begin
					write_reg(perf_pkg::REG_SCR_W, 16'($urandom_range(4096, 1)));
					write_reg(perf_pkg::REG_SCR_H, 16'($urandom_range(4096, 1)));
					write_reg(perf_pkg::REG_SPAN_X, 16'($urandom_range(65535)));
					write_reg(perf_pkg::REG_SPAN_Y, 16'($urandom_range(2000)));
				end
			endcase
			// a run of syncs fills the ring past full, then pops drain it
			if (batch == 3) begin
				repeat (260) add(1'b0, perf_pkg::EV_SYN, 10'd0, 32'd0);
				repeat (258) add(1'b1, 5'd0, 10'd0, 32'd0);
			end
			repeat (90) add_random((batch % 3 == 0) ? 3 : ((batch % 3 == 1) ? 20 : 45));
			wait_idle();
		end

		$display("covered %0d queued, %0d dropped, %0d popped, %0d empty pops",
			n_queued, n_dropped, n_popped, n_empty);
		$display("over all four device classes with extreme screen and span settings");
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// timeout
	initial begin
		#50ms;
		$display("Verification failed");
		$finish;
	end

endmodule
